>>> rtl/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg
// Types and constants shared by the rectangle collide/split block.
// ----------------------------------------------------------------------------
package rcs_pkg;

   localparam int COORD_BITS = 16;
   // Edges (x + width) need one extra bit of range plus a sign bit
   localparam int EDGE_BITS  = COORD_BITS + 2;

   localparam logic [2:0] OUTCOME_APART         = 3'd0;
   localparam logic [2:0] OUTCOME_RESIDENT_COV  = 3'd1;
   localparam logic [2:0] OUTCOME_INCOMING_COV  = 3'd2;
   localparam logic [2:0] OUTCOME_RESIDENT_CUT  = 3'd3;
   localparam logic [2:0] OUTCOME_INCOMING_CUT  = 3'd4;
   localparam logic [2:0] OUTCOME_MERGED        = 3'd5;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] resident_x;
      logic signed [COORD_BITS-1:0] resident_y;
      logic        [COORD_BITS-1:0] resident_width;
      logic        [COORD_BITS-1:0] resident_height;
      logic signed [COORD_BITS-1:0] incoming_x;
      logic signed [COORD_BITS-1:0] incoming_y;
      logic        [COORD_BITS-1:0] incoming_width;
      logic        [COORD_BITS-1:0] incoming_height;
   } req_type;

   typedef struct packed {
      logic [2:0]                   outcome;
      logic [1:0]                   piece_count;
      logic signed [COORD_BITS-1:0] first_x;
      logic signed [COORD_BITS-1:0] first_y;
      logic        [COORD_BITS-1:0] first_width;
      logic        [COORD_BITS-1:0] first_height;
      logic signed [COORD_BITS-1:0] second_x;
      logic signed [COORD_BITS-1:0] second_y;
      logic        [COORD_BITS-1:0] second_width;
      logic        [COORD_BITS-1:0] second_height;
   } rsp_type;

endpackage

>>> rtl/rcs_core.sv
// ----------------------------------------------------------------------------
// rcs_core
// Classifies a resident/new rectangle pair and computes the remaining pieces.
// ----------------------------------------------------------------------------
module rcs_core
   import rcs_pkg::*;
(
   input  req_type req,
   output rsp_type rsp
);

   typedef logic [COORD_BITS-1:0] crd_type;
   typedef logic signed [EDGE_BITS-1:0] edge_type;

   function automatic edge_type sx(input crd_type v);
      sx = edge_type'($signed({{(EDGE_BITS-COORD_BITS){v[COORD_BITS-1]}}, v}));
   endfunction

   function automatic edge_type zx(input crd_type v);
      zx = edge_type'($signed({{(EDGE_BITS-COORD_BITS){1'b0}}, v}));
   endfunction

   function automatic logic pt_in(input edge_type px, input edge_type py,
                                  input edge_type lx, input edge_type hx,
                                  input edge_type ly, input edge_type hy);
      pt_in = (px >= lx) && (px <= hx) && (py >= ly) && (py <= hy);
   endfunction

   function automatic logic [2:0] cnt4(input logic [3:0] v);
      cnt4 = {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
   endfunction

   // exact edges
   edge_type ax, ay, ax1, ay1, bx, by, bx1, by1;
   // wrapped fields
   crd_type  wax, way, waw, wah, wbx, wby, wbw, wbh;
   crd_type  wax1, way1, wbx1, wby1;
   logic     cov_res, cov_inc, apart;
   logic     r0, r1, r2, r3, s0, s1, s2, s3;
   logic [2:0] t1, t2;

   assign wax = crd_type'(req.resident_x);
   assign way = crd_type'(req.resident_y);
   assign waw = req.resident_width;
   assign wah = req.resident_height;
   assign wbx = crd_type'(req.incoming_x);
   assign wby = crd_type'(req.incoming_y);
   assign wbw = req.incoming_width;
   assign wbh = req.incoming_height;

   assign ax  = sx(wax);
   assign ay  = sx(way);
   assign bx  = sx(wbx);
   assign by  = sx(wby);
   assign ax1 = ax + zx(waw);
   assign ay1 = ay + zx(wah);
   assign bx1 = bx + zx(wbw);
   assign by1 = by + zx(wbh);

   assign wax1 = ax1[COORD_BITS-1:0];
   assign way1 = ay1[COORD_BITS-1:0];
   assign wbx1 = bx1[COORD_BITS-1:0];
   assign wby1 = by1[COORD_BITS-1:0];

   assign cov_res = (ax >= bx) && (ax1 <= bx1) && (ay >= by) && (ay1 <= by1);
   assign cov_inc = (bx >= ax) && (bx1 <= ax1) && (by >= ay) && (by1 <= ay1);
   assign apart   = (ax1 < bx) || (bx1 < ax) || (ay1 < by) || (by1 < ay);

   assign r0 = pt_in(ax,  ay,  bx, bx1, by, by1);
   assign r1 = pt_in(ax1, ay,  bx, bx1, by, by1);
   assign r2 = pt_in(ax,  ay1, bx, bx1, by, by1);
   assign r3 = pt_in(ax1, ay1, bx, bx1, by, by1);
   assign s0 = pt_in(bx,  by,  ax, ax1, ay, ay1);
   assign s1 = pt_in(bx1, by,  ax, ax1, ay, ay1);
   assign s2 = pt_in(bx,  by1, ax, ax1, ay, ay1);
   assign s3 = pt_in(bx1, by1, ax, ax1, ay, ay1);

   assign t1 = cnt4({r3, r2, r1, r0});
   assign t2 = cnt4({s3, s2, s1, s0});

   always_comb begin
      rsp = '0;
      if (cov_res) begin
         rsp.outcome = OUTCOME_RESIDENT_COV;
      end else if (cov_inc) begin
         rsp.outcome = OUTCOME_INCOMING_COV;
      end else if (apart) begin
         rsp.outcome = OUTCOME_APART;
      end else if (t1 == 3'd2 && t2 == 3'd2 && s0 && s1 && waw == wbw) begin
         rsp.outcome      = OUTCOME_MERGED;
         rsp.piece_count  = 2'd1;
         rsp.first_x      = wax;
         rsp.first_y      = way;
         rsp.first_width  = waw;
         rsp.first_height = wbh + wby - way;
      end else if (t1 == 3'd2 && t2 == 3'd2 && s0 && s2 && wah == wbh) begin
         rsp.outcome      = OUTCOME_MERGED;
         rsp.piece_count  = 2'd1;
         rsp.first_x      = wax;
         rsp.first_y      = way;
         rsp.first_width  = wbw + wbx - wax;
         rsp.first_height = wah;
      end else if (t1 == 3'd2 && t2 == 3'd2 && s3 && s1 && wah == wbh) begin
         rsp.outcome      = OUTCOME_MERGED;
         rsp.piece_count  = 2'd1;
         rsp.first_x      = wbx;
         rsp.first_y      = wby;
         rsp.first_width  = waw + wax - wbx;
         rsp.first_height = wbh;
      end else if (t1 == 3'd2 && t2 == 3'd2 && s3 && s2 && waw == wbw) begin
         rsp.outcome      = OUTCOME_MERGED;
         rsp.piece_count  = 2'd1;
         rsp.first_x      = wbx;
         rsp.first_y      = wby;
         rsp.first_width  = wbw;
         rsp.first_height = wah + way - wby;
      end else if (t2 == 3'd2) begin
         // trim the new rectangle along the shared side
         rsp.outcome      = OUTCOME_INCOMING_CUT;
         rsp.piece_count  = 2'd1;
         rsp.first_x      = wbx;
         rsp.first_y      = wby;
         rsp.first_width  = wbw;
         rsp.first_height = wbh;
         if (s0 && s1) begin
            rsp.first_y      = way1;
            rsp.first_height = wbh - (way1 - wby);
         end else if (s0 && s2) begin
            rsp.first_x     = wax1;
            rsp.first_width = wbw - (wax1 - wbx);
         end else if (s3 && s1) begin
            rsp.first_width = wbw - (wbx1 - wax);
         end else if (s3 && s2) begin
            rsp.first_height = wbh - (wby1 - way);
         end
      end else if (t1 == 3'd2) begin
         rsp.outcome      = OUTCOME_RESIDENT_CUT;
         rsp.piece_count  = 2'd1;
         rsp.first_x      = wax;
         rsp.first_y      = way;
         rsp.first_width  = waw;
         rsp.first_height = wah;
         if (r0 && r1) begin
            rsp.first_y      = wby1;
            rsp.first_height = wah - (wby1 - way);
         end else if (r0 && r2) begin
            rsp.first_x     = wbx1;
            rsp.first_width = waw - (wbx1 - wax);
         end else if (r3 && r1) begin
            rsp.first_width = waw - (wax1 - wbx);
         end else if (r3 && r2) begin
            rsp.first_height = wah - (way1 - wby);
         end
      end else if (t2 == 3'd1) begin
         // one corner of the new rectangle inside: two L pieces
         rsp.outcome     = OUTCOME_INCOMING_CUT;
         rsp.piece_count = 2'd2;
         if (s0) begin
            rsp.first_x       = wax1;
            rsp.first_y       = wby;
            rsp.first_width   = wbw - wax1 + wbx;
            rsp.first_height  = wbh;
            rsp.second_x      = wbx;
            rsp.second_y      = way1;
            rsp.second_width  = wax1 - wbx;
            rsp.second_height = wbh - way1 + wby;
         end else if (s1) begin
            rsp.first_x       = wbx;
            rsp.first_y       = wby;
            rsp.first_width   = wbw - wbx1 + wax;
            rsp.first_height  = wbh;
            rsp.second_x      = wax;
            rsp.second_y      = way1;
            rsp.second_width  = wbx1 - wax;
            rsp.second_height = wbh - way1 + wby;
         end else if (s2) begin
            rsp.first_x       = wax1;
            rsp.first_y       = wby;
            rsp.first_width   = wbw - wax1 + wbx;
            rsp.first_height  = wbh;
            rsp.second_x      = wbx;
            rsp.second_y      = wby;
            rsp.second_width  = wax1 - wbx;
            rsp.second_height = wbh - wby1 + way;
         end else begin
            rsp.first_x       = wbx;
            rsp.first_y       = wby;
            rsp.first_width   = wbw - wbx1 + wax;
            rsp.first_height  = wbh;
            rsp.second_x      = wax;
            rsp.second_y      = wby;
            rsp.second_width  = wbx1 - wax;
            rsp.second_height = wbh - wby1 + way;
         end
      end else begin
         // crossing: split the new rectangle around the resident band
         rsp.outcome     = OUTCOME_INCOMING_CUT;
         rsp.piece_count = 2'd2;
         if (by < ay) begin
            rsp.first_x       = wbx;
            rsp.first_y       = wby;
            rsp.first_width   = wbw;
            rsp.first_height  = wbh - wby1 + way;
            rsp.second_x      = wbx;
            rsp.second_y      = way1;
            rsp.second_width  = wbw;
            rsp.second_height = wby1 - way1;
         end else begin
            rsp.first_x       = wbx;
            rsp.first_y       = wby;
            rsp.first_width   = wbw - wbx1 + wax;
            rsp.first_height  = wbh;
            rsp.second_x      = wax1;
            rsp.second_y      = wby;
            rsp.second_width  = wbx1 - wax1;
            rsp.second_height = wbh;
         end
      end
   end

endmodule

>>> rtl/rect_collide_split.sv
// ----------------------------------------------------------------------------
// rect_collide_split
// Rectangle pair classifier with input and result registers.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_data carry one rectangle pair per item; the
//   block raises req_stall only when both its registers hold items and the
//   receiver stalls the result.
//   rsp_valid/rsp_stall/rsp_data carry one classification per item: the
//   outcome code, the piece count and up to two pieces (unused ones zero).
// Path: an accepted item is registered in the input register, classified by
//   combinational logic, and held in the result register once that register
//   can take it; rsp_valid rises when the result register is loaded.
// Throughput: one item per cycle while the receiver does not stall, set by
//   the single compare/add stage between the input and result registers.
// Reset: clears both valid flags; no item is held afterward.
// Receiver stall: the result register holds its item; the input register
//   takes one more item if it is empty, then req_stall rises until rsp_stall drops.
// ----------------------------------------------------------------------------
module rect_collide_split
   import rcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   req_type in_ff;
   logic    in_vld_ff, in_vld_in;
   rsp_type out_ff, out_in;
   logic    out_vld_ff, out_vld_in;
   logic    out_take, in_take;

   rcs_core u_core (
      .req (in_ff),
      .rsp (out_in)
   );

   assign out_take  = !out_vld_ff || !rsp_stall;
   assign in_take   = !in_vld_ff || out_take;
   assign req_stall = !in_take;

   assign in_vld_in  = in_take ? req_valid : in_vld_ff;
   assign out_vld_in = out_take ? in_vld_ff : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && req_valid) begin
         in_ff <= req_data;
      end
      if (out_take && in_vld_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule
